/* rtl/core/ps2dec_pkg.sv */
// ----------------------------------------------------------------------------
// ps2dec_pkg
// shared codes, widths and the key event type of the set 2 scan code decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ps2dec_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CODE_W = 9;
	localparam int unsigned MOD_W  = 6;

	localparam logic [BYTE_W-1:0] SC_EXT      = 8'hE0;
	localparam logic [BYTE_W-1:0] SC_BREAK    = 8'hF0;
	localparam logic [BYTE_W-1:0] SC_PAUSE    = 8'hE1;
	localparam logic [BYTE_W-1:0] SC_CAPS     = 8'h58;
	localparam logic [BYTE_W-1:0] SC_SCROLL   = 8'h7E;
	localparam logic [BYTE_W-1:0] SC_NUM      = 8'h77;
	localparam logic [BYTE_W-1:0] SC_PRTSC    = 8'h7C;
	localparam logic [BYTE_W-1:0] SC_LCTRL    = 8'h14;
	localparam logic [BYTE_W-1:0] SC_LSHIFT   = 8'h12;

	localparam logic [CODE_W-1:0] KC_LALT     = 9'h011;
	localparam logic [CODE_W-1:0] KC_LSHIFT   = 9'h012;
	localparam logic [CODE_W-1:0] KC_LCTRL    = 9'h014;
	localparam logic [CODE_W-1:0] KC_RSHIFT   = 9'h059;
	localparam logic [CODE_W-1:0] KC_RALT     = 9'h111;
	localparam logic [CODE_W-1:0] KC_RCTRL    = 9'h114;
	localparam logic [CODE_W-1:0] KC_PRINTSCR = 9'h17C;
	localparam logic [CODE_W-1:0] KC_PAUSE    = 9'h177;

	typedef struct packed {
		logic [CODE_W-1:0] key_code;
		logic              is_release;
		logic              caps_on;
		logic              num_on;
		logic              scroll_on;
		logic [MOD_W-1:0]  modifiers;
	} key_event_t;

	function automatic logic [MOD_W-1:0] mod_mask(input logic [CODE_W-1:0] code);
		logic [MOD_W-1:0] m;
		m = '0;
		unique case (code)
			KC_LALT:   m = 6'b000001;
			KC_LSHIFT: m = 6'b000010;
			KC_LCTRL:  m = 6'b000100;
			KC_RSHIFT: m = 6'b001000;
			KC_RALT:   m = 6'b010000;
			KC_RCTRL:  m = 6'b100000;
			default:   m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/ps2dec_if.sv */
// ----------------------------------------------------------------------------
// ps2dec channel interfaces
// valid/ready channels for raw keyboard bytes and decoded key events
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2dec_byte_if import ps2dec_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2dec_event_if import ps2dec_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] key_code;
	logic              is_release;
	logic              caps_on;
	logic              num_on;
	logic              scroll_on;
	logic [MOD_W-1:0]  modifiers;

	modport source (output valid, output key_code, output is_release, output caps_on,
		output num_on, output scroll_on, output modifiers, input ready);
	modport sink   (input valid, input key_code, input is_release, input caps_on,
		input num_on, input scroll_on, input modifiers, output ready);
endinterface

`default_nettype wire

/* rtl/core/ps2dec_core.sv */
// ----------------------------------------------------------------------------
// ps2dec_core
// prefix history, skip queue, lock and modifier state; decodes one byte per
// step and reports the key event it completes, if any
// ----------------------------------------------------------------------------
`default_nettype none

module ps2dec_core import ps2dec_pkg::*; #(
	parameter int unsigned PREFIX_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] ch,
	output logic              emit,
	output key_event_t        evt
);

	localparam int unsigned CW = $clog2(PREFIX_DEPTH + 1);
	localparam int unsigned IW = $clog2(PREFIX_DEPTH);

	logic [BYTE_W-1:0] prefix_q [PREFIX_DEPTH];
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [BYTE_W-1:0] skip_b0_q, skip_b0_d, skip_b1_q, skip_b1_d;
	logic [1:0]        skip_cnt_q, skip_cnt_d;
	logic              caps_q, caps_d, num_q, num_d, scroll_q, scroll_d;
	logic [MOD_W-1:0]  mods_q, mods_d, mask;

	logic              hold_en;
	logic [IW-1:0]     hold_idx;
	logic              lk_caps, lk_num, lk_scroll, lock_cur, lock_set, lock_clr;
	logic [CODE_W-1:0] code;
	logic              rel;
	logic              n0, n1, n2, n3, n5, n7;
	logic              skip_hit;

	assign n0 = (cnt_q == CW'(0));
	assign n1 = (cnt_q == CW'(1));
	assign n2 = (cnt_q == CW'(2));
	assign n3 = (cnt_q == CW'(3));
	assign n5 = (cnt_q == CW'(5));
	assign n7 = (cnt_q == CW'(7));
	assign skip_hit = (skip_cnt_q != 2'd0) && (skip_b0_q == ch);

	always_comb begin
		cnt_d      = cnt_q;
		skip_cnt_d = skip_cnt_q;
		skip_b0_d  = skip_b0_q;
		skip_b1_d  = skip_b1_q;
		hold_en    = 1'b0;
		hold_idx   = '0;
		lk_caps    = 1'b0;
		lk_num     = 1'b0;
		lk_scroll  = 1'b0;
		emit       = 1'b0;
		code       = {1'b0, ch};
		rel        = 1'b0;
		if (skip_hit) begin
			skip_cnt_d = skip_cnt_q - 2'd1;
			if (skip_cnt_q == 2'd2) begin
				skip_b0_d = skip_b1_q;
			end
		end else begin
			case (ch) inside
				SC_CAPS: begin
					lk_caps = 1'b1;
				end
				SC_SCROLL: begin
					lk_scroll = 1'b1;
				end
				SC_NUM: begin
					if (n2 && prefix_q[0] == SC_PAUSE && prefix_q[1] == SC_LCTRL) begin
						hold_en  = 1'b1;
						hold_idx = IW'(2);
						cnt_d    = CW'(3);
					end else if (n7 && prefix_q[0] == SC_PAUSE && prefix_q[1] == SC_LCTRL
							&& prefix_q[2] == SC_NUM && prefix_q[3] == SC_PAUSE
							&& prefix_q[4] == SC_BREAK && prefix_q[5] == SC_LCTRL
							&& prefix_q[6] == SC_BREAK) begin
						cnt_d = '0;
						emit  = 1'b1;
						code  = KC_PAUSE;
					end else begin
						lk_num = 1'b1;
					end
				end
				SC_EXT, SC_BREAK: begin
					if (cnt_q < CW'(PREFIX_DEPTH)) begin
						hold_en  = 1'b1;
						hold_idx = cnt_q[IW-1:0];
						cnt_d    = cnt_q + CW'(1);
					end
				end
				default: begin
					cnt_d = '0;
					if (n0 && ch == SC_PAUSE) begin
						hold_en  = 1'b1;
						hold_idx = IW'(0);
						cnt_d    = CW'(1);
					end else if (n1) begin
						if (prefix_q[0] == SC_EXT) begin
							if (ch == SC_LSHIFT) begin
								hold_en  = 1'b1;
								hold_idx = IW'(1);
								cnt_d    = CW'(2);
							end else begin
								emit = 1'b1;
								code = {1'b1, ch};
							end
						end else if (prefix_q[0] == SC_BREAK) begin
							emit = 1'b1;
							rel  = 1'b1;
						end else if (prefix_q[0] == SC_PAUSE && ch == SC_LCTRL) begin
							hold_en  = 1'b1;
							hold_idx = IW'(1);
							cnt_d    = CW'(2);
						end else begin
							emit = 1'b1;
						end
					end else if (n2) begin
						if (prefix_q[0] == SC_EXT && prefix_q[1] == SC_BREAK) begin
							if (ch == SC_PRTSC) begin
								hold_en  = 1'b1;
								hold_idx = IW'(2);
								cnt_d    = CW'(3);
							end else begin
								emit = 1'b1;
								code = {1'b1, ch};
								rel  = 1'b1;
							end
						end else begin
							emit = 1'b1;
						end
					end else if (n3) begin
						if (prefix_q[0] == SC_EXT && prefix_q[1] == SC_LSHIFT
								&& prefix_q[2] == SC_EXT && ch == SC_PRTSC) begin
							emit = 1'b1;
							code = KC_PRINTSCR;
						end else if (prefix_q[0] == SC_PAUSE && prefix_q[1] == SC_LCTRL
								&& prefix_q[2] == SC_NUM && ch == SC_PAUSE) begin
							hold_en  = 1'b1;
							hold_idx = IW'(3);
							cnt_d    = CW'(4);
						end else begin
							emit = 1'b1;
						end
					end else if (n5) begin
						if (prefix_q[0] == SC_EXT && prefix_q[1] == SC_BREAK
								&& prefix_q[2] == SC_PRTSC && prefix_q[3] == SC_EXT
								&& prefix_q[4] == SC_BREAK && ch == SC_LSHIFT) begin
							emit = 1'b1;
							code = KC_PRINTSCR;
							rel  = 1'b1;
						end else if (prefix_q[0] == SC_PAUSE && prefix_q[1] == SC_LCTRL
								&& prefix_q[2] == SC_NUM && prefix_q[3] == SC_PAUSE
								&& prefix_q[4] == SC_BREAK && ch == SC_LCTRL) begin
							hold_en  = 1'b1;
							hold_idx = IW'(5);
							cnt_d    = CW'(6);
						end else begin
							emit = 1'b1;
						end
					end else begin
						emit = 1'b1;
					end
				end
			endcase
		end

		// lock key handling
		lock_cur = (lk_caps & caps_q) | (lk_num & num_q) | (lk_scroll & scroll_q);
		lock_set = 1'b0;
		lock_clr = 1'b0;
		if (lk_caps | lk_num | lk_scroll) begin
			if (lock_cur) begin
				cnt_d = '0;
				if (n0) begin
					hold_en  = 1'b1;
					hold_idx = IW'(0);
					cnt_d    = CW'(1);
				end else if (n2 && prefix_q[0] == ch && prefix_q[1] == SC_BREAK) begin
					lock_clr = 1'b1;
				end
			end else begin
				lock_set   = 1'b1;
				skip_b0_d  = SC_BREAK;
				skip_b1_d  = ch;
				skip_cnt_d = 2'd2;
			end
		end
		caps_d   = lk_caps   ? ((caps_q   | lock_set) & ~lock_clr) : caps_q;
		num_d    = lk_num    ? ((num_q    | lock_set) & ~lock_clr) : num_q;
		scroll_d = lk_scroll ? ((scroll_q | lock_set) & ~lock_clr) : scroll_q;

		mask   = mod_mask(code);
		mods_d = mods_q;
		if (emit) begin
			mods_d = rel ? (mods_q & ~mask) : (mods_q | mask);
		end
	end

	assign evt.key_code   = code;
	assign evt.is_release = rel;
	assign evt.caps_on    = caps_q;
	assign evt.num_on     = num_q;
	assign evt.scroll_on  = scroll_q;
	assign evt.modifiers  = mods_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			skip_cnt_q <= '0;
			caps_q     <= 1'b0;
			num_q      <= 1'b0;
			scroll_q   <= 1'b0;
			mods_q     <= '0;
		end else if (step) begin
			cnt_q      <= cnt_d;
			skip_cnt_q <= skip_cnt_d;
			caps_q     <= caps_d;
			num_q      <= num_d;
			scroll_q   <= scroll_d;
			mods_q     <= mods_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			skip_b0_q <= skip_b0_d;
			skip_b1_q <= skip_b1_d;
			if (hold_en) begin
				prefix_q[hold_idx] <= ch;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ps2_set2_scancode_decoder.sv */
// ----------------------------------------------------------------------------
// ps2_set2_scancode_decoder
// PS/2 scan code set 2 byte stream to key event decoder
// ----------------------------------------------------------------------------
// One keyboard byte is taken per request on the scan channel and each byte
// that completes a key yields one request on the key channel: a 9-bit code
// with bit 8 set for extended keys (0x17C print screen, 0x177 pause), a
// release flag, the caps, num and scroll lock bits and six held modifier bits
// (lalt, lshift, lctrl, rshift, ralt, rctrl from bit 0). Prefix bytes and the
// lock keys themselves produce no event. A taken byte is held in a register
// until it is decoded, and its event is registered into the output register
// as it is decoded; a new byte can be taken every cycle, and the input stalls
// only while the output register holds an event that has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_set2_scancode_decoder import ps2dec_pkg::*; #(
	parameter int unsigned PREFIX_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	ps2dec_byte_if.sink      scan,
	ps2dec_event_if.source   key
);

	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              go_s1;
	logic              emit;
	key_event_t        evt;
	logic              out_v_q;
	key_event_t        out_q;

	assign go_s1      = v_s1 && (!out_v_q || key.ready);
	assign scan.ready = !v_s1 || go_s1;

	ps2dec_core #(
		.PREFIX_DEPTH (PREFIX_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (go_s1),
		.ch     (byte_s1),
		.emit   (emit),
		.evt    (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (scan.ready) begin
				v_s1 <= scan.valid;
			end
			if (go_s1 && emit) begin
				out_v_q <= 1'b1;
			end else if (key.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			byte_s1 <= scan.scan_byte;
		end
		if (go_s1 && emit) begin
			out_q <= evt;
		end
	end

	assign key.valid      = out_v_q;
	assign key.key_code   = out_q.key_code;
	assign key.is_release = out_q.is_release;
	assign key.caps_on    = out_q.caps_on;
	assign key.num_on     = out_q.num_on;
	assign key.scroll_on  = out_q.scroll_on;
	assign key.modifiers  = out_q.modifiers;

endmodule

`default_nettype wire
